>>> hw/rtl/sddm_pkg.sv
// shared types, constants and functions of the dop sigma-delta modulator
package sddm_pkg;

	// default sizes
	localparam int MAX_CHANNELS_DEF     = 8;
	localparam int MAX_ORDER_DEF        = 8;
	localparam int IDLE_LOCK_FRAMES_DEF = 96;

	// fixed widths (order index covers the whole order range)
	localparam int IDX_W = 3;
	localparam int RUN_W = 7;

	// register indexes
	typedef enum logic [2:0] {
		REG_CHANNEL_COUNT  = 3'd0,
		REG_FILTER_ORDER   = 3'd1,
		REG_DITHER_AMP     = 3'd2,
		REG_INPUT_LIMIT    = 3'd3,
		REG_STAB_LIMIT     = 3'd4,
		REG_COEF_LOW       = 3'd5,
		REG_COEF_HIGH      = 3'd6
	} reg_idx_t;

	// register reset values
	localparam logic [3:0]  CHANNEL_COUNT_RST = 4'd2;
	localparam logic [3:0]  FILTER_ORDER_RST  = 4'd1;
	localparam logic [30:0] INPUT_LIMIT_RST   = 31'd16777216;
	localparam logic [30:0] STAB_LIMIT_RST    = 31'd67108864;

	// q8.24 constants
	localparam logic signed [41:0] ONE_Q24     = 42'sd16777216;
	localparam logic [31:0]        THR_SILENCE = 32'd2013;
	localparam logic [31:0]        THR_LOCK    = 32'd5872;
	localparam logic [31:0]        THR_UNLOCK  = 32'd15099;

	// output bytes
	localparam logic [7:0] SILENCE_BYTE = 8'h69;
	localparam logic [7:0] MARKER_EVEN  = 8'h05;
	localparam logic [7:0] MARKER_ODD   = 8'hfa;

	// dither generator
	localparam logic [31:0] LCG_ZERO_SEED = 32'h9e3779b9;
	localparam logic [31:0] LCG_MUL       = 32'd1664525;
	localparam logic [31:0] LCG_ADD       = 32'd1013904223;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_EVAL,
		ST_LCG,
		ST_MAC,
		ST_SUM,
		ST_DEC,
		ST_STORE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             accept;
		logic             load;
		logic             eval;
		logic             lcg;
		logic             mac;
		logic             sum;
		logic             dec;
		logic             store;
		logic             out_load;
		logic [IDX_W-1:0] idx;
		logic [3:0]       bit_idx;
	} dp_cmd_t;

	typedef struct packed {
		logic             silence;
		logic [IDX_W-1:0] order_last;
	} dp_status_t;

	function automatic logic [31:0] lcg_next(input logic [31:0] s);
		logic [31:0] b;
		b = (s == 32'd0) ? LCG_ZERO_SEED : s;
		return 32'(b * LCG_MUL) + LCG_ADD;
	endfunction

	function automatic logic signed [31:0] clamp_sym(input logic signed [41:0] v,
		input logic [30:0] lim);
		logic signed [41:0] hi;
		logic signed [41:0] lo;
		hi = $signed({11'd0, lim});
		lo = -hi;
		if (v > hi) begin
			return hi[31:0];
		end else if (v < lo) begin
			return lo[31:0];
		end
		return v[31:0];
	endfunction

endpackage

>>> hw/rtl/sigma_delta_dop_modulator_core.sv
// top level of the dop sigma-delta modulator: controller plus datapath
// One transfer on the input carries one PCM sample (signed Q8.24) of the channel
// picked by an internal counter that walks channel_count interleaved channels; the
// DoP marker flips between 0x05 and 0xFA from frame to frame. Each sample is split
// into 16 interpolated sub-samples, each decided by a single shared 16x32 feedback
// multiplier over filter_order error taps. An item runs the history load, the idle
// check, the 16 decisions (dither step, taps, sum, decision) and the history
// write-back, then its result goes to the output register; a channel held silent
// by the idle detector skips the 16 decisions. The next sample is taken once the
// previous one is finished, even while its result still waits in the output
// register. After reset the error history reads as zero through per-entry valid
// bits, so no clearing pass is needed.
module sigma_delta_dop_modulator_core #(
	parameter int MAX_CHANNELS     = sddm_pkg::MAX_CHANNELS_DEF,
	parameter int MAX_ORDER        = sddm_pkg::MAX_ORDER_DEF,
	parameter int IDLE_LOCK_FRAMES = sddm_pkg::IDLE_LOCK_FRAMES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration writes
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	// sample input
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] pcm_sample,
	// dop word output
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         first_byte,
	output logic [7:0]         second_byte,
	output logic [7:0]         marker_byte
);

	// command and status between sequencer and datapath
	sddm_pkg::dp_cmd_t    cmd;
	sddm_pkg::dp_status_t st;

	// sequencer: load, idle check, 16 decisions, write-back, result transfer
	sddm_ctrl #(
		.MAX_ORDER(MAX_ORDER)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.st        (st)
	);

	// registers, channel state, error history and arithmetic
	sddm_datapath #(
		.MAX_CHANNELS    (MAX_CHANNELS),
		.MAX_ORDER       (MAX_ORDER),
		.IDLE_LOCK_FRAMES(IDLE_LOCK_FRAMES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pcm_sample  (pcm_sample),
		.cmd         (cmd),
		.st          (st),
		.first_byte  (first_byte),
		.second_byte (second_byte),
		.marker_byte (marker_byte)
	);

endmodule

>>> hw/rtl/sddm_ctrl.sv
// controller state machine of the dop sigma-delta modulator
module sddm_ctrl #(
	parameter int MAX_ORDER = sddm_pkg::MAX_ORDER_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	output sddm_pkg::dp_cmd_t    cmd,
	input  sddm_pkg::dp_status_t st
);

	localparam logic [sddm_pkg::IDX_W-1:0] LAST_IDX = sddm_pkg::IDX_W'(MAX_ORDER - 1);

	sddm_pkg::state_t state_q, state_d;
	logic [sddm_pkg::IDX_W-1:0] idx_q;
	logic [3:0] bit_q;
	logic       out_valid_q;
	logic       can_load;

	assign can_load  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign in_stall  = (state_q != sddm_pkg::ST_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sddm_pkg::ST_IDLE: begin
				if (in_valid) state_d = sddm_pkg::ST_LOAD;
			end
			sddm_pkg::ST_LOAD: begin
				if (idx_q == LAST_IDX) state_d = sddm_pkg::ST_EVAL;
			end
			sddm_pkg::ST_EVAL: begin
				state_d = st.silence ? sddm_pkg::ST_STORE : sddm_pkg::ST_LCG;
			end
			sddm_pkg::ST_LCG: begin
				state_d = sddm_pkg::ST_MAC;
			end
			sddm_pkg::ST_MAC: begin
				if (idx_q == st.order_last) state_d = sddm_pkg::ST_SUM;
			end
			sddm_pkg::ST_SUM: begin
				state_d = sddm_pkg::ST_DEC;
			end
			sddm_pkg::ST_DEC: begin
				state_d = (bit_q == 4'd15) ? sddm_pkg::ST_STORE : sddm_pkg::ST_LCG;
			end
			sddm_pkg::ST_STORE: begin
				if (idx_q == LAST_IDX) begin
					state_d = can_load ? sddm_pkg::ST_IDLE : sddm_pkg::ST_DONE;
				end
			end
			sddm_pkg::ST_DONE: begin
				if (can_load) state_d = sddm_pkg::ST_IDLE;
			end
			default: state_d = sddm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.idx      = idx_q;
		cmd.bit_idx  = bit_q;
		cmd.accept   = (state_q == sddm_pkg::ST_IDLE) && in_valid;
		cmd.load     = (state_q == sddm_pkg::ST_LOAD);
		cmd.eval     = (state_q == sddm_pkg::ST_EVAL);
		cmd.lcg      = (state_q == sddm_pkg::ST_LCG);
		cmd.mac      = (state_q == sddm_pkg::ST_MAC);
		cmd.sum      = (state_q == sddm_pkg::ST_SUM);
		cmd.dec      = (state_q == sddm_pkg::ST_DEC);
		cmd.store    = (state_q == sddm_pkg::ST_STORE);
		cmd.out_load = can_load && (((state_q == sddm_pkg::ST_STORE) && (idx_q == LAST_IDX))
			|| (state_q == sddm_pkg::ST_DONE));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sddm_pkg::ST_IDLE;
			idx_q       <= '0;
			bit_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) begin
				idx_q <= '0;
			end else if (cmd.load || cmd.mac || cmd.store) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.eval) begin
				bit_q <= '0;
			end else if (cmd.dec) begin
				bit_q <= bit_q + 4'd1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("result register overwritten while held");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == sddm_pkg::ST_LOAD))
		else $error("accepted transfer did not start history load");

	a_tap_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sddm_pkg::ST_MAC) |-> (idx_q <= st.order_last))
		else $error("feedback tap beyond order");

endmodule

>>> hw/rtl/sddm_datapath.sv
// datapath of the dop sigma-delta modulator: config, channel state, history, arithmetic
module sddm_datapath #(
	parameter int MAX_CHANNELS     = sddm_pkg::MAX_CHANNELS_DEF,
	parameter int MAX_ORDER        = sddm_pkg::MAX_ORDER_DEF,
	parameter int IDLE_LOCK_FRAMES = sddm_pkg::IDLE_LOCK_FRAMES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [63:0]           cfg_data,
	input  logic signed [31:0]    pcm_sample,
	input  sddm_pkg::dp_cmd_t     cmd,
	output sddm_pkg::dp_status_t  st,
	output logic [7:0]            first_byte,
	output logic [7:0]            second_byte,
	output logic [7:0]            marker_byte
);

	localparam int CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int OW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
	localparam int DEPTH = MAX_CHANNELS * MAX_ORDER;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [sddm_pkg::RUN_W-1:0] RUN_MAX = sddm_pkg::RUN_W'(IDLE_LOCK_FRAMES);

	// configuration registers
	logic [3:0]  chan_cnt_q, order_q;
	logic [30:0] dith_amp_q, in_lim_q, stab_lim_q;
	logic [63:0] coef_lo_q, coef_hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_cnt_q <= sddm_pkg::CHANNEL_COUNT_RST;
			order_q    <= sddm_pkg::FILTER_ORDER_RST;
			dith_amp_q <= '0;
			in_lim_q   <= sddm_pkg::INPUT_LIMIT_RST;
			stab_lim_q <= sddm_pkg::STAB_LIMIT_RST;
			coef_lo_q  <= '0;
			coef_hi_q  <= '0;
		end else if (cfg_we) begin
			unique case (sddm_pkg::reg_idx_t'(cfg_index))
				sddm_pkg::REG_CHANNEL_COUNT: chan_cnt_q <= cfg_data[3:0];
				sddm_pkg::REG_FILTER_ORDER:  order_q    <= cfg_data[3:0];
				sddm_pkg::REG_DITHER_AMP:    dith_amp_q <= cfg_data[30:0];
				sddm_pkg::REG_INPUT_LIMIT:   in_lim_q   <= cfg_data[30:0];
				sddm_pkg::REG_STAB_LIMIT:    stab_lim_q <= cfg_data[30:0];
				sddm_pkg::REG_COEF_LOW:      coef_lo_q  <= cfg_data;
				sddm_pkg::REG_COEF_HIGH:     coef_hi_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective order
	logic [3:0] order_eff;
	always_comb begin
		if (order_q == 4'd0) order_eff = 4'd1;
		else if (order_q > MAX_ORDER) order_eff = 4'(MAX_ORDER);
		else order_eff = order_q;
	end
	assign st.order_last = sddm_pkg::IDX_W'(order_eff - 4'd1);

	// per channel state
	logic [31:0]               seed_q [MAX_CHANNELS];
	logic [sddm_pkg::RUN_W-1:0] run_q [MAX_CHANNELS];
	logic                      lock_q [MAX_CHANNELS];
	logic signed [31:0]        last_q [MAX_CHANNELS];
	logic [CW-1:0]             pos_q, ch_q;
	logic                      parity_q;

	// item registers
	logic [7:0]         marker_q;
	logic signed [31:0] cur_q, prev_q;
	logic signed [32:0] diff_q;
	logic signed [37:0] dacc_q;
	logic [31:0]        seed_w_q;
	logic signed [31:0] dith_q;
	logic signed [50:0] fb_acc_q;
	logic signed [41:0] total_q;
	logic [15:0]        bits_q;
	logic               silence_q;
	logic signed [31:0] hist_q [MAX_ORDER];

	// channel selection at accept
	logic [4:0]         cnt_eff, ch_next;
	logic [CW-1:0]      ch_sel;
	logic signed [31:0] cur_in, prev_in;
	always_comb begin
		if (chan_cnt_q == 4'd0) cnt_eff = 5'd1;
		else if (chan_cnt_q > MAX_CHANNELS) cnt_eff = 5'(MAX_CHANNELS);
		else cnt_eff = {1'b0, chan_cnt_q};
		ch_sel  = (5'(pos_q) >= cnt_eff) ? '0 : pos_q;
		ch_next = 5'(ch_sel) + 5'd1;
		cur_in  = sddm_pkg::clamp_sym({{10{pcm_sample[31]}}, pcm_sample}, in_lim_q);
		prev_in = sddm_pkg::clamp_sym({{10{last_q[ch_sel][31]}}, last_q[ch_sel]}, in_lim_q);
	end

	// idle detector
	logic [31:0]               mag;
	logic [sddm_pkg::RUN_W-1:0] run_cur, run_inc, run_d;
	logic                      lock_d, sil_d;
	always_comb begin
		mag     = cur_q[31] ? 32'(-cur_q) : 32'(cur_q);
		run_cur = run_q[ch_q];
		run_inc = (run_cur >= RUN_MAX) ? RUN_MAX : run_cur + 1'b1;
		run_d   = '0;
		lock_d  = 1'b0;
		sil_d   = 1'b0;
		if (lock_q[ch_q]) begin
			if (mag < sddm_pkg::THR_UNLOCK) begin
				run_d  = run_inc;
				lock_d = 1'b1;
				sil_d  = 1'b1;
			end
		end else if (mag <= sddm_pkg::THR_SILENCE) begin
			run_d  = RUN_MAX;
			lock_d = 1'b1;
			sil_d  = 1'b1;
		end else if (mag <= sddm_pkg::THR_LOCK) begin
			run_d = run_inc;
			if (run_inc >= RUN_MAX) begin
				lock_d = 1'b1;
				sil_d  = 1'b1;
			end
		end
	end
	assign st.silence = sil_d;

	// arithmetic
	logic [31:0]        seed_nx;
	logic signed [63:0] dith_prod;
	logic [127:0]       coefs;
	logic signed [15:0] coef;
	logic signed [31:0] hv;
	logic signed [47:0] mac_prod;
	logic signed [41:0] prev_w, dacc_w, sub_w, dith_w;
	logic signed [50:0] fb_sh;
	logic signed [31:0] dec, err;
	logic signed [41:0] err_raw;
	always_comb begin
		seed_nx   = sddm_pkg::lcg_next(seed_q[ch_q]);
		dith_prod = $signed({~seed_w_q[31], seed_w_q[30:0]}) * $signed({1'b0, dith_amp_q});
		coefs     = {coef_hi_q, coef_lo_q};
		coef      = $signed(coefs[{cmd.idx, 4'd0} +: 16]);
		hv        = hist_q[cmd.idx[OW-1:0]];
		mac_prod  = coef * hv;
		prev_w    = {{10{prev_q[31]}}, prev_q};
		dacc_w    = {{4{dacc_q[37]}}, dacc_q};
		sub_w     = prev_w + (dacc_w >>> 4);
		dith_w    = {{10{dith_q[31]}}, dith_q};
		fb_sh     = fb_acc_q >>> 12;
		dec       = sddm_pkg::clamp_sym(total_q, stab_lim_q);
		err_raw   = dec[31] ? {{10{dec[31]}}, dec} + sddm_pkg::ONE_Q24
			: {{10{dec[31]}}, dec} - sddm_pkg::ONE_Q24;
		err       = sddm_pkg::clamp_sym(err_raw, stab_lim_q);
	end

	// error history memory
	logic [31:0]       err_mem [DEPTH];
	logic              err_vld_q [DEPTH];
	logic [AW-1:0]     mem_addr;
	logic [31:0]       wr_data;
	logic [31:0]       rd_data_s1;
	logic              rd_vld_s1;
	logic              ld_en_s1;
	logic [OW-1:0]     ld_idx_s1;

	assign mem_addr = AW'(ch_q * MAX_ORDER + cmd.idx);
	assign wr_data  = silence_q ? 32'd0 : hv;

	always_ff @(posedge clk) begin
		if (cmd.store) err_mem[mem_addr] <= wr_data;
		if (cmd.load) rd_data_s1 <= err_mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) err_vld_q[i] <= 1'b0;
			rd_vld_s1 <= 1'b0;
			ld_en_s1  <= 1'b0;
			ld_idx_s1 <= '0;
		end else begin
			if (cmd.store) err_vld_q[mem_addr] <= 1'b1;
			if (cmd.load) rd_vld_s1 <= err_vld_q[mem_addr];
			ld_en_s1  <= cmd.load;
			ld_idx_s1 <= cmd.idx[OW-1:0];
		end
	end

	// working history
	always_ff @(posedge clk) begin
		if (ld_en_s1) begin
			hist_q[ld_idx_s1] <= rd_vld_s1 ? $signed(rd_data_s1) : 32'sd0;
		end else if (cmd.dec) begin
			for (int i = 1; i < MAX_ORDER; i++) begin
				if (i <= int'(st.order_last)) hist_q[i] <= hist_q[i-1];
			end
			hist_q[0] <= err;
		end
	end

	// channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				seed_q[i] <= '0;
				run_q[i]  <= '0;
				lock_q[i] <= 1'b0;
				last_q[i] <= '0;
			end
			pos_q    <= '0;
			parity_q <= 1'b0;
			ch_q     <= '0;
		end else begin
			if (cmd.accept) begin
				ch_q <= ch_sel;
				if (ch_next >= cnt_eff) begin
					pos_q    <= '0;
					parity_q <= ~parity_q;
				end else begin
					pos_q <= CW'(ch_next);
				end
			end
			if (cmd.eval) begin
				run_q[ch_q]  <= run_d;
				lock_q[ch_q] <= lock_d;
				last_q[ch_q] <= sil_d ? 32'sd0 : cur_q;
			end
			if (cmd.lcg) seed_q[ch_q] <= seed_nx;
		end
	end

	// item datapath
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			marker_q <= parity_q ? sddm_pkg::MARKER_ODD : sddm_pkg::MARKER_EVEN;
			cur_q    <= cur_in;
			prev_q   <= prev_in;
		end
		if (cmd.eval) begin
			silence_q <= sil_d;
			diff_q    <= {cur_q[31], cur_q} - {prev_q[31], prev_q};
			dacc_q    <= '0;
			bits_q    <= '0;
		end
		if (cmd.lcg) begin
			seed_w_q <= seed_nx;
			dacc_q   <= dacc_q + {{5{diff_q[32]}}, diff_q};
			fb_acc_q <= '0;
		end
		if (cmd.mac) begin
			dith_q   <= dith_prod[63:32];
			fb_acc_q <= fb_acc_q + {{3{mac_prod[47]}}, mac_prod};
		end
		if (cmd.sum) total_q <= sub_w + dith_w + $signed(fb_sh[41:0]);
		if (cmd.dec) bits_q[cmd.bit_idx] <= !dec[31];
		if (cmd.out_load) begin
			first_byte  <= silence_q ? sddm_pkg::SILENCE_BYTE : bits_q[7:0];
			second_byte <= silence_q ? sddm_pkg::SILENCE_BYTE : bits_q[15:8];
			marker_byte <= marker_q;
		end
	end

endmodule

>>> dv/tb_sigma_delta_dop_modulator_core.sv
// testbench of the dop sigma-delta modulator core: directed and random samples, checked per word
module tb_sigma_delta_dop_modulator_core;
	timeunit 1ns;
	timeprecision 1ps;

	// one dop word as the block presents it
	typedef struct {
		logic [7:0] first;
		logic [7:0] second;
		logic [7:0] marker;
	} dop_word_t;

	// kinds of sample material the random part draws from
	typedef enum int {
		MAT_LOUD,
		MAT_MUSIC,
		MAT_QUIET,
		MAT_SILENT,
		MAT_MIXED
	} material_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [63:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [31:0] pcm_sample = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [7:0]         first_byte;
	logic [7:0]         second_byte;
	logic [7:0]         marker_byte;

	sigma_delta_dop_modulator_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pcm_sample (pcm_sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.first_byte (first_byte),
		.second_byte(second_byte),
		.marker_byte(marker_byte)
	);

	// words predicted but not yet seen at the output
	dop_word_t pending_words[$];

	// idling controls of the sender and of the receiver
	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	int hold_off_cycles = 0;
	bit hold_off = 1'b0;

	int mismatch_cnt = 0;
	int sample_cnt = 0;
	int word_cnt = 0;
	int cfg_cnt = 0;
	int silent_cnt = 0;

	// modulator copy: configuration
	logic [3:0]  m_count;
	logic [3:0]  m_order;
	logic [30:0] m_dither_amp;
	logic [30:0] m_in_limit;
	logic [30:0] m_stab_limit;
	logic [63:0] m_coef_lo;
	logic [63:0] m_coef_hi;

	// modulator copy: state
	longint      m_err_hist[8][8];
	logic [31:0] m_seed[8];
	int          m_run[8];
	bit          m_locked[8];
	longint      m_last[8];
	int          m_pos;
	bit          m_parity;

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// overall time limit
	initial begin
		#30ms;
		$display("TB_ERROR");
		$finish;
	end

	function automatic longint clamp_to(input longint v, input longint lim);
		if (v > lim) begin
			return lim;
		end
		if (v < -lim) begin
			return -lim;
		end
		return v;
	endfunction

	// signed q4.12 feedback coefficient k
	function automatic longint feedback_coef(input int k);
		logic [63:0] w;
		logic [15:0] h;
		w = (k < 4) ? m_coef_lo : m_coef_hi;
		h = w[(k % 4) * 16 +: 16];
		return longint'($signed(h));
	endfunction

	function automatic logic [31:0] dither_advance(input logic [31:0] s);
		logic [63:0] b;
		b = (s == 32'd0) ? 64'(sddm_pkg::LCG_ZERO_SEED) : 64'(s);
		return 32'(b * 64'(sddm_pkg::LCG_MUL) + 64'(sddm_pkg::LCG_ADD));
	endfunction

	function automatic void modulator_reset();
		m_count      = sddm_pkg::CHANNEL_COUNT_RST;
		m_order      = sddm_pkg::FILTER_ORDER_RST;
		m_dither_amp = '0;
		m_in_limit   = sddm_pkg::INPUT_LIMIT_RST;
		m_stab_limit = sddm_pkg::STAB_LIMIT_RST;
		m_coef_lo    = '0;
		m_coef_hi    = '0;
		for (int c = 0; c < 8; c++) begin
			for (int i = 0; i < 8; i++) begin
				m_err_hist[c][i] = 0;
			end
			m_seed[c]   = '0;
			m_run[c]    = 0;
			m_locked[c] = 1'b0;
			m_last[c]   = 0;
		end
		m_pos    = 0;
		m_parity = 1'b0;
	endfunction

	// works out the dop word one accepted sample produces and advances the copy
	function automatic dop_word_t modulate_sample(input logic signed [31:0] raw);
		dop_word_t w;
		int        cnt;
		int        ord;
		int        ch;
		int        run;
		bit        silent;
		longint    cur;
		longint    prev;
		longint    mag;
		longint    dith;
		longint    sub;
		longint    acc;
		longint    dec;
		longint    err;

		cnt = (m_count < 1) ? 1 : ((m_count > 8) ? 8 : m_count);
		ord = (m_order < 1) ? 1 : ((m_order > 8) ? 8 : m_order);
		// count lowered mid-frame: start over without a parity flip
		if (m_pos >= cnt) begin
			m_pos = 0;
		end
		ch = m_pos;
		silent = 1'b0;
		w.first = '0;
		w.second = '0;
		w.marker = m_parity ? sddm_pkg::MARKER_ODD : sddm_pkg::MARKER_EVEN;

		cur = clamp_to(longint'(raw), longint'(m_in_limit));
		prev = clamp_to(m_last[ch], longint'(m_in_limit));
		mag = (cur < 0) ? -cur : cur;

		// idle detector
		run = m_run[ch];
		if (m_locked[ch]) begin
			if (mag < longint'(sddm_pkg::THR_UNLOCK)) begin
				run = (run + 1 > 96) ? 96 : run + 1;
				silent = 1'b1;
			end else begin
				m_locked[ch] = 1'b0;
				run = 0;
			end
		end else if (mag <= longint'(sddm_pkg::THR_SILENCE)) begin
			m_locked[ch] = 1'b1;
			run = 96;
			silent = 1'b1;
		end else if (mag <= longint'(sddm_pkg::THR_LOCK)) begin
			run = (run + 1 > 96) ? 96 : run + 1;
			if (run >= 96) begin
				m_locked[ch] = 1'b1;
				silent = 1'b1;
			end
		end else begin
			run = 0;
		end
		m_run[ch] = run;

		if (silent) begin
			for (int i = 0; i < 8; i++) begin
				m_err_hist[ch][i] = 0;
			end
			m_last[ch] = 0;
			w.first = sddm_pkg::SILENCE_BYTE;
			w.second = sddm_pkg::SILENCE_BYTE;
		end else begin
			for (int b = 0; b < 16; b++) begin
				m_seed[ch] = dither_advance(m_seed[ch]);
				dith = ((longint'(m_seed[ch]) - 64'sd2147483648) *
					longint'(m_dither_amp)) >>> 32;
				sub = prev + (((cur - prev) * longint'(b + 1)) >>> 4);
				acc = 0;
				for (int i = 0; i < ord; i++) begin
					acc += feedback_coef(i) * m_err_hist[ch][i];
				end
				dec = clamp_to(sub + dith + (acc >>> 12), longint'(m_stab_limit));
				err = clamp_to((dec >= 0) ? dec - longint'(sddm_pkg::ONE_Q24)
					: dec + longint'(sddm_pkg::ONE_Q24), longint'(m_stab_limit));
				// slots beyond the order in use stay untouched
				for (int i = ord - 1; i > 0; i--) begin
					m_err_hist[ch][i] = m_err_hist[ch][i - 1];
				end
				m_err_hist[ch][0] = err;
				if (dec >= 0) begin
					if (b < 8) begin
						w.first[b] = 1'b1;
					end else begin
						w.second[b - 8] = 1'b1;
					end
				end
			end
			m_last[ch] = cur;
		end

		m_pos = ch + 1;
		if (m_pos >= cnt) begin
			m_pos = 0;
			m_parity = ~m_parity;
		end
		return w;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at word %0d: %s", word_cnt, msg);
		mismatch_cnt++;
	endtask

	// long receiver hold-off, counted down cycle by cycle
	always @(posedge clk) begin
		if (hold_off_cycles > 0) begin
			hold_off_cycles--;
			hold_off <= 1'b1;
		end else begin
			hold_off <= 1'b0;
		end
	end

	// receiver: random stalls, long hold-off on request, checks each transfer
	always @(posedge clk) begin
		dop_word_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_words.size() == 0) begin
					report_mismatch($sformatf("unexpected dop word %02h %02h %02h",
						first_byte, second_byte, marker_byte));
				end else begin
					want = pending_words.pop_front();
					if (first_byte !== want.first) begin
						report_mismatch($sformatf("first_byte expected %02h, got %02h",
							want.first, first_byte));
					end
					if (second_byte !== want.second) begin
						report_mismatch($sformatf("second_byte expected %02h, got %02h",
							want.second, second_byte));
					end
					if (marker_byte !== want.marker) begin
						report_mismatch($sformatf("marker_byte expected %02h, got %02h",
							want.marker, marker_byte));
					end
					if (want.first == sddm_pkg::SILENCE_BYTE
						&& want.second == sddm_pkg::SILENCE_BYTE) begin
						silent_cnt++;
					end
				end
				word_cnt++;
			end
			// a long hold-off fills the block so its input stalls
			if (hold_off) begin
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// one sample transfer; valid stays high afterwards until idled or released
	task automatic send_sample(input logic signed [31:0] x);
		dop_word_t w;
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pcm_sample <= x;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		w = modulate_sample(x);
		pending_words = {pending_words, w};
		sample_cnt++;
	endtask

	// stop offering and wait until every predicted word has come out
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
	endtask

	// register write; the block is idle whenever this is called after drain
	task automatic write_reg(input sddm_pkg::reg_idx_t idx, input logic [63:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			sddm_pkg::REG_CHANNEL_COUNT: m_count = value[3:0];
			sddm_pkg::REG_FILTER_ORDER:  m_order = value[3:0];
			sddm_pkg::REG_DITHER_AMP:    m_dither_amp = value[30:0];
			sddm_pkg::REG_INPUT_LIMIT:   m_in_limit = value[30:0];
			sddm_pkg::REG_STAB_LIMIT:    m_stab_limit = value[30:0];
			sddm_pkg::REG_COEF_LOW:      m_coef_lo = value;
			sddm_pkg::REG_COEF_HIGH:     m_coef_hi = value;
			default: ;
		endcase
		cfg_cnt++;
	endtask

	// sample drawn from one kind of material
	function automatic logic signed [31:0] pick_sample(input material_t mat);
		int mag;
		material_t m;
		m = mat;
		if (mat == MAT_MIXED || $urandom_range(9) == 0) begin
			m = material_t'($urandom_range(3));
		end
		case (m)
			MAT_LOUD:   return $urandom();
			MAT_MUSIC:  mag = $urandom_range(32'h0200_0000);
			MAT_QUIET:  mag = $urandom_range(5872, 2014);
			MAT_SILENT: mag = $urandom_range(2013);
			default:    mag = $urandom_range(15099, 5873);
		endcase
		return $urandom_range(1) ? -mag : mag;
	endfunction

	// extremes of the fields and the idle thresholds at reset settings and wide limits
	task automatic test_directed_extremes();
		logic signed [31:0] pts[$];
		pts = '{32'sh7fffffff, -32'sh80000000, 0, 1, -1, 2013, -2013, 2014, 5872, -5873,
			15098, 15099, -15099, 32'sh0100_0000, -32'sh0100_0000, 32'sh00ff_ffff};
		foreach (pts[i]) begin
			send_sample(pts[i]);
		end
		drain();
		write_reg(sddm_pkg::REG_INPUT_LIMIT, 64'h7fff_ffff);
		write_reg(sddm_pkg::REG_STAB_LIMIT, 64'h7fff_ffff);
		write_reg(sddm_pkg::REG_COEF_LOW, 64'h0000_0000_0000_1000);
		send_sample(32'sh7fffffff);
		send_sample(-32'sh80000000);
		send_sample(32'sh4000_0000);
		send_sample(-32'sh4000_0000);
		drain();
	endtask

	// out-of-range count and order, count lowered mid-frame, zero limits, order change
	task automatic test_special_cases();
		write_reg(sddm_pkg::REG_INPUT_LIMIT, 64'h0400_0000);
		write_reg(sddm_pkg::REG_STAB_LIMIT, 64'h0400_0000);
		write_reg(sddm_pkg::REG_COEF_LOW, 64'hf000_0800_e000_2000);
		write_reg(sddm_pkg::REG_COEF_HIGH, 64'h0400_fc00_0200_ff00);
		write_reg(sddm_pkg::REG_CHANNEL_COUNT, 64'd0);
		write_reg(sddm_pkg::REG_FILTER_ORDER, 64'd0);
		repeat (4) send_sample(pick_sample(MAT_MUSIC));
		drain();
		write_reg(sddm_pkg::REG_CHANNEL_COUNT, 64'd15);
		write_reg(sddm_pkg::REG_FILTER_ORDER, 64'd15);
		repeat (10) send_sample(pick_sample(MAT_MUSIC));
		drain();
		// three into a four-channel frame, then the frame shrinks to two
		write_reg(sddm_pkg::REG_CHANNEL_COUNT, 64'd4);
		repeat (3) send_sample(pick_sample(MAT_MUSIC));
		drain();
		write_reg(sddm_pkg::REG_CHANNEL_COUNT, 64'd2);
		repeat (3) send_sample(pick_sample(MAT_MUSIC));
		drain();
		// history slots past the order must survive a shorter order
		write_reg(sddm_pkg::REG_FILTER_ORDER, 64'd8);
		repeat (4) send_sample(pick_sample(MAT_MUSIC));
		drain();
		write_reg(sddm_pkg::REG_FILTER_ORDER, 64'd2);
		repeat (4) send_sample(pick_sample(MAT_MUSIC));
		drain();
		write_reg(sddm_pkg::REG_FILTER_ORDER, 64'd8);
		repeat (4) send_sample(pick_sample(MAT_MUSIC));
		drain();
		write_reg(sddm_pkg::REG_INPUT_LIMIT, 64'd0);
		repeat (3) send_sample(pick_sample(MAT_LOUD));
		drain();
		write_reg(sddm_pkg::REG_INPUT_LIMIT, 64'h0100_0000);
		write_reg(sddm_pkg::REG_STAB_LIMIT, 64'd0);
		repeat (3) send_sample(pick_sample(MAT_LOUD));
		drain();
		write_reg(sddm_pkg::REG_STAB_LIMIT, 64'h0400_0000);
	endtask

	// quiet run long enough to lock, hold below unlock, then break out
	task automatic test_idle_lock();
		write_reg(sddm_pkg::REG_CHANNEL_COUNT, 64'd1);
		write_reg(sddm_pkg::REG_DITHER_AMP, 64'h0000_4000);
		repeat (100) send_sample(pick_sample(MAT_QUIET));
		send_sample(15098);
		send_sample(-9000);
		send_sample(-15099);
		send_sample(4000);
		send_sample(0);
		send_sample(32'sh0080_0000);
		drain();
	endtask

	task automatic randomize_config(input int phase);
		logic [63:0] v;
		if (phase == 0) begin
			write_reg(sddm_pkg::REG_CHANNEL_COUNT, 64'd8);
			write_reg(sddm_pkg::REG_FILTER_ORDER, 64'd8);
			write_reg(sddm_pkg::REG_DITHER_AMP, 64'h7fff_ffff);
			write_reg(sddm_pkg::REG_INPUT_LIMIT, 64'h7fff_ffff);
			write_reg(sddm_pkg::REG_STAB_LIMIT, 64'h7fff_ffff);
			write_reg(sddm_pkg::REG_COEF_LOW, '1);
			write_reg(sddm_pkg::REG_COEF_HIGH, 64'h8000_8000_7fff_7fff);
		end else if (phase == 1) begin
			write_reg(sddm_pkg::REG_CHANNEL_COUNT, 64'd1);
			write_reg(sddm_pkg::REG_FILTER_ORDER, 64'd1);
			write_reg(sddm_pkg::REG_DITHER_AMP, 64'd0);
			write_reg(sddm_pkg::REG_INPUT_LIMIT, 64'd1);
			write_reg(sddm_pkg::REG_STAB_LIMIT, 64'd1);
			write_reg(sddm_pkg::REG_COEF_LOW, 64'd0);
			write_reg(sddm_pkg::REG_COEF_HIGH, 64'd0);
		end else begin
			v = ($urandom_range(7) == 0) ? 64'($urandom_range(15)) : 64'($urandom_range(8, 1));
			write_reg(sddm_pkg::REG_CHANNEL_COUNT, v);
			v = ($urandom_range(7) == 0) ? 64'($urandom_range(15)) : 64'($urandom_range(8, 1));
			write_reg(sddm_pkg::REG_FILTER_ORDER, v);
			v = ($urandom_range(3) == 0) ? 64'($urandom()) : 64'($urandom_range(32'h0040_0000));
			write_reg(sddm_pkg::REG_DITHER_AMP, v);
			v = ($urandom_range(3) == 0) ? 64'($urandom()) :
				64'($urandom_range(32'h0200_0000, 32'h0080_0000));
			write_reg(sddm_pkg::REG_INPUT_LIMIT, v);
			v = ($urandom_range(3) == 0) ? 64'($urandom()) :
				64'($urandom_range(32'h0800_0000, 32'h0100_0000));
			write_reg(sddm_pkg::REG_STAB_LIMIT, v);
			write_reg(sddm_pkg::REG_COEF_LOW, {$urandom(), $urandom()});
			write_reg(sddm_pkg::REG_COEF_HIGH, {$urandom(), $urandom()});
		end
	endtask

	// random phases, each with its own settings and sample material
	task automatic test_random_phases();
		material_t mat;
		for (int phase = 0; phase < 15; phase++) begin
			randomize_config(phase);
			if (phase < 5) begin
				send_gap_pct = 8;
				recv_stall_pct = 80;
			end else if (phase < 10) begin
				send_gap_pct = 80;
				recv_stall_pct = 8;
			end else begin
				send_gap_pct = 0;
				recv_stall_pct = 0;
			end
			// receiver blocks for a long stretch while samples keep coming
			if (phase == 12) begin
				hold_off_cycles = 3000;
			end
			mat = material_t'($urandom_range(4));
			for (int n = 0; n < 100; n++) begin
				send_sample(pick_sample(mat));
			end
			drain();
		end
	endtask

	initial begin
		modulator_reset();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_extremes();
		test_special_cases();
		test_idle_lock();
		test_random_phases();
		drain();
		repeat (400) @(posedge clk);
		$display("covered %0d samples, %0d dop words (%0d silent), %0d register writes",
			sample_cnt, word_cnt, silent_cnt, cfg_cnt);
		$display("with sender gaps, receiver stalls and one long output hold-off");
		if (mismatch_cnt == 0 && pending_words.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
